[src/tce_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tce_pkg
// Shared types and constants for the tiny CPU execute core.
// ----------------------------------------------------------------------------
package tce_pkg;

    localparam int unsigned WordWidth = 8;
    localparam int unsigned NumRegs   = 4;
    localparam logic [7:0]  TxAddr    = 8'd253;

    typedef logic [WordWidth-1:0] word_t;
    typedef logic [NumRegs-1:0][WordWidth-1:0] regfile_t;

    typedef enum logic [3:0] {
        OP_MOV  = 4'h0,
        OP_ADD  = 4'h1,
        OP_SUB  = 4'h2,
        OP_AND  = 4'h3,
        OP_OR   = 4'h4,
        OP_NOT  = 4'h5,
        OP_SHL  = 4'h6,
        OP_SHR  = 4'h7,
        OP_SHR2 = 4'h8,
        OP_CMP  = 4'h9,
        OP_JF   = 4'ha,
        OP_JMP  = 4'hb,
        OP_LDIH = 4'hc,
        OP_LDIL = 4'hd,
        OP_LD   = 4'he,
        OP_ST   = 4'hf
    } op_t;

    typedef struct packed {
        regfile_t regs;
        word_t    pc;
        logic     flag;
        logic     st_en;
        word_t    st_addr;
        word_t    st_data;
        logic     tx_wr;
    } exec_t;

endpackage
`default_nettype wire

[src/tiny_cpu_execute_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tiny_cpu_execute_core
// Execute stage of a four-register 8-bit machine with a 256-byte data RAM.
//
// The instr channel takes one instruction byte per beat, the byte fetched at
// the program counter reported by the previous result. Each beat is latched
// in an input register and executed, once the result can move on, by a
// single pass of decode and ALU logic; the architectural registers double
// as the result register, which holds the result beat.
// One instruction is taken every cycle while the receiver keeps up.
// The data RAM read for a load is issued in the cycle the instruction is
// taken, with forwarding of the register and store of the instruction
// executing in that same cycle.
// When the receiver stalls, the result holds and at most one further
// instruction waits in the input register; in_ready then drops.
// Reset clears the registers, program counter, flag and transmit byte; the
// RAM is not cleared and must be written before it is read.
// ----------------------------------------------------------------------------
module tiny_cpu_execute_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] instr,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      next_pc,
    output logic [7:0]      reg_zero,
    output logic [7:0]      reg_one,
    output logic [7:0]      reg_two,
    output logic [7:0]      reg_three,
    output logic            cmp_flag,
    output logic [7:0]      tx_byte,
    output logic            tx_written
);

    logic              ivalid_reg;
    logic [7:0]        instr_reg;
    logic              ovalid_reg;
    tce_pkg::regfile_t regs_reg;
    tce_pkg::word_t    pc_reg;
    logic              flag_reg;
    tce_pkg::word_t    tx_reg;
    logic              txw_reg;
    tce_pkg::word_t    rdata_reg;
    tce_pkg::word_t    ram_mem [256];

    tce_pkg::exec_t    exec;
    logic              fire;
    logic              accept;
    tce_pkg::word_t    raddr;

    tce_alu u_alu (
        .instr     (instr_reg),
        .regs      (regs_reg),
        .pc        (pc_reg),
        .flag      (flag_reg),
        .ram_rdata (rdata_reg),
        .result    (exec)
    );

    assign fire     = ivalid_reg && (!ovalid_reg || out_ready);
    assign in_ready = !ivalid_reg || fire;
    assign accept   = in_valid && in_ready;
    assign raddr    = fire ? exec.regs[instr[1:0]] : regs_reg[instr[1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ivalid_reg <= 1'b0;
            ovalid_reg <= 1'b0;
            regs_reg   <= '0;
            pc_reg     <= '0;
            flag_reg   <= 1'b0;
            tx_reg     <= '0;
            txw_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                ivalid_reg <= 1'b1;
            end
            else if (fire)
            begin
                ivalid_reg <= 1'b0;
            end
            if (fire)
            begin
                ovalid_reg <= 1'b1;
                regs_reg   <= exec.regs;
                pc_reg     <= exec.pc;
                flag_reg   <= exec.flag;
                txw_reg    <= exec.tx_wr;
                if (exec.tx_wr)
                begin
                    tx_reg <= exec.st_data;
                end
            end
            else if (out_ready)
            begin
                ovalid_reg <= 1'b0;
                txw_reg    <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            instr_reg <= instr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && exec.st_en)
        begin
            ram_mem[exec.st_addr] <= exec.st_data;
        end
        if (accept)
        begin
            if (fire && exec.st_en && (exec.st_addr == raddr))
            begin
                rdata_reg <= exec.st_data;
            end
            else
            begin
                rdata_reg <= ram_mem[raddr];
            end
        end
    end

    assign out_valid  = ovalid_reg;
    assign next_pc    = pc_reg;
    assign reg_zero   = regs_reg[0];
    assign reg_one    = regs_reg[1];
    assign reg_two    = regs_reg[2];
    assign reg_three  = regs_reg[3];
    assign cmp_flag   = flag_reg;
    assign tx_byte    = tx_reg;
    assign tx_written = txw_reg;

    a_txw_valid: assert property (@(posedge clk) disable iff (!rst_n)
        tx_written |-> out_valid)
        else $error("tx_written set without a result beat");

    a_jf_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (instr_reg[7:4] == tce_pkg::OP_JF) && flag_reg) |=> !cmp_flag)
        else $error("taken conditional jump left the flag set");

    a_pc_step: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (instr_reg[7:4] != tce_pkg::OP_JF) && (instr_reg[7:4] != tce_pkg::OP_JMP))
        |=> (next_pc == $past(next_pc) + 8'd1))
        else $error("program counter did not advance by one");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ivalid_reg && out_valid && !out_ready) |=> (ivalid_reg && out_valid))
        else $error("queued instruction lost during output stall");

endmodule
`default_nettype wire

[src/tce_alu.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tce_alu
// Decodes one instruction and computes the machine state it leaves behind,
// together with the RAM store it requests.
// ----------------------------------------------------------------------------
module tce_alu (
    input  wire logic [7:0]       instr,
    input  wire tce_pkg::regfile_t regs,
    input  wire tce_pkg::word_t   pc,
    input  wire logic             flag,
    input  wire tce_pkg::word_t   ram_rdata,
    output tce_pkg::exec_t        result
);

    tce_pkg::op_t   op;
    logic [1:0]     rd;
    logic [1:0]     rs;
    logic [3:0]     imm;
    tce_pkg::word_t a;
    tce_pkg::word_t b;

    assign op  = tce_pkg::op_t'(instr[7:4]);
    assign rd  = instr[3:2];
    assign rs  = instr[1:0];
    assign imm = instr[3:0];
    assign a   = regs[rd];
    assign b   = regs[rs];

    always_comb
    begin
        result         = '0;
        result.regs    = regs;
        result.pc      = pc + 8'd1;
        result.flag    = flag;
        result.st_addr = b;
        result.st_data = a;
        case (op)
            tce_pkg::OP_MOV:  result.regs[rd] = b;
            tce_pkg::OP_ADD:  result.regs[rd] = a + b;
            tce_pkg::OP_SUB:  result.regs[rd] = a - b;
            tce_pkg::OP_AND:  result.regs[rd] = a & b;
            tce_pkg::OP_OR:   result.regs[rd] = a | b;
            tce_pkg::OP_NOT:  result.regs[rd] = ~b;
            tce_pkg::OP_SHL:  result.regs[rd] = (b >= 8'd8) ? 8'd0 : (a << b[2:0]);
            tce_pkg::OP_SHR,
            tce_pkg::OP_SHR2: result.regs[rd] = (b >= 8'd8) ? 8'd0 : (a >> b[2:0]);
            tce_pkg::OP_CMP:  result.flag = (a == b);
            tce_pkg::OP_JF:
            begin
                if (flag)
                begin
                    result.pc   = b;
                    result.flag = 1'b0;
                end
            end
            tce_pkg::OP_JMP:  result.pc = b;
            tce_pkg::OP_LDIH: result.regs[3] = regs[3] | {imm, 4'h0};
            tce_pkg::OP_LDIL: result.regs[3] = {4'h0, imm};
            tce_pkg::OP_LD:   result.regs[rd] = ram_rdata;
            tce_pkg::OP_ST:
            begin
                result.st_en = 1'b1;
                result.tx_wr = (b == tce_pkg::TxAddr);
            end
            default:
            begin
                result.st_en = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire
